### rtl/skf_pkg.sv
package skf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int GAIN_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int RND_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_STEPS = GAIN_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd1;

  localparam logic [63:0] Q_ONE = 64'd1 << FRAC_BITS;
  localparam logic [DATA_W-1:0] PN_RESET  = DATA_W'((64'd8 * Q_ONE + 64'd50) / 64'd100);
  localparam logic [DATA_W-1:0] MN_RESET  = DATA_W'((64'd3 * Q_ONE) / 64'd4);
  localparam logic [DATA_W-1:0] VAR_RESET = DATA_W'(Q_ONE);
  localparam logic [DATA_W:0]   HALF      = (DATA_W + 1)'(Q_ONE >> 1);

  localparam logic [GAIN_BITS-1:0] GAIN_MAX = '1;
  localparam logic [GAIN_BITS:0]   GAIN_ONE = (GAIN_BITS + 1)'(1) << GAIN_BITS;

  typedef struct packed {
    logic accept;
    logic prime;
    logic predict;
    logic div_init;
    logic div_step;
    logic mul;
    logic update;
    logic out_load;
  } cmd_t;

endpackage

### rtl/skf_ctrl.sv
module skf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output skf_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PRED  = 3'd1;
  localparam logic [2:0] ST_DINIT = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_UPD   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]                 state_r, state_nxt;
  logic [skf_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       primed_r, primed_nxt;
  logic                       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    primed_nxt = primed_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          cmd.prime  = !primed_r;
          primed_nxt = 1'b1;
          state_nxt  = primed_r ? ST_PRED : ST_FIN;
        end
      end
      ST_PRED: begin
        cmd.predict = 1'b1;
        state_nxt   = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == skf_pkg::CNT_W'(skf_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      primed_r    <= primed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/skf_dp.sv
module skf_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  skf_pkg::cmd_t                       cmd,
  input  logic                                cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [skf_pkg::DATA_W-1:0]          cfg_data,
  input  logic signed [skf_pkg::DATA_W-1:0]   in_measurement,
  output logic signed [skf_pkg::DATA_W-1:0]   out_estimate,
  output logic signed [skf_pkg::RND_W-1:0]    out_rounded_estimate,
  output logic [skf_pkg::DATA_W-1:0]          out_error_variance
);

  localparam int W  = skf_pkg::DATA_W;
  localparam int GB = skf_pkg::GAIN_BITS;
  localparam int PE = GB + 1 + W + 1;
  localparam int PV = W + GB + 1;

  localparam logic signed [W+1:0] EST_MAX = (W + 2)'((64'd1 << (W - 1)) - 64'd1);
  localparam logic signed [W+1:0] EST_MIN = -(W + 2)'(64'd1 << (W - 1));
  localparam logic signed [W:0]   RND_MAX = (W + 1)'((64'd1 << (skf_pkg::RND_W - 1)) - 64'd1);
  localparam logic signed [W:0]   RND_MIN = -(W + 1)'(64'd1 << (skf_pkg::RND_W - 1));

  logic [W-1:0]                 pn_r, mn_r;
  logic signed [W-1:0]          meas_r, est_r;
  logic [W-1:0]                 var_r, pq_r;
  logic [W:0]                   den_r, rem_r;
  logic [GB-1:0]                g_r;
  logic                         byp_r;
  logic signed [PE-1:0]         prod_e_r;
  logic [PV-1:0]                prod_v_r;
  logic signed [W-1:0]          out_est_r;
  logic signed [skf_pkg::RND_W-1:0] out_rnd_r;
  logic [W-1:0]                 out_var_r;

  logic [W:0]                   p_sum;
  logic [W-1:0]                 p_sat;
  logic [W+1:0]                 rem_sh;
  logic                         rem_ge;
  logic [W+1:0]                 rem_sub;
  logic signed [W:0]            innov;
  logic signed [PE-1:0]         prod_e_nxt;
  logic [GB:0]                  gain_cmp;
  logic [PV-1:0]                prod_v_nxt;
  logic signed [W+1:0]          delta;
  logic signed [W+1:0]          est_sum;
  logic signed [W-1:0]          est_new;
  logic signed [W:0]            rnd_sum;
  logic signed [W:0]            rnd_full;
  logic signed [skf_pkg::RND_W-1:0] rnd_sat;

  assign p_sum   = {1'b0, var_r} + {1'b0, pn_r};
  assign p_sat   = p_sum[W] ? '1 : p_sum[W-1:0];
  assign rem_sh  = {rem_r, 1'b0};
  assign rem_ge  = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  assign innov      = $signed({meas_r[W-1], meas_r}) - $signed({est_r[W-1], est_r});
  assign prod_e_nxt = $signed({1'b0, g_r}) * innov;
  assign gain_cmp   = skf_pkg::GAIN_ONE - {1'b0, g_r};
  assign prod_v_nxt = pq_r * gain_cmp;

  assign delta   = prod_e_r[GB+W+1:GB];
  assign est_sum = $signed({{2{est_r[W-1]}}, est_r}) + delta;

  always_comb begin
    if (est_sum > EST_MAX) begin
      est_new = EST_MAX[W-1:0];
    end else if (est_sum < EST_MIN) begin
      est_new = EST_MIN[W-1:0];
    end else begin
      est_new = est_sum[W-1:0];
    end
  end

  assign rnd_sum  = $signed({est_r[W-1], est_r}) + $signed(skf_pkg::HALF);
  assign rnd_full = rnd_sum >>> skf_pkg::FRAC_BITS;

  always_comb begin
    if (rnd_full > RND_MAX) begin
      rnd_sat = RND_MAX[skf_pkg::RND_W-1:0];
    end else if (rnd_full < RND_MIN) begin
      rnd_sat = RND_MIN[skf_pkg::RND_W-1:0];
    end else begin
      rnd_sat = rnd_full[skf_pkg::RND_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pn_r  <= skf_pkg::PN_RESET;
      mn_r  <= skf_pkg::MN_RESET;
      est_r <= '0;
      var_r <= skf_pkg::VAR_RESET;
    end else begin
      if (cfg_we && cfg_index == skf_pkg::CFG_PROCESS_NOISE) begin
        pn_r <= cfg_data;
      end
      if (cfg_we && cfg_index == skf_pkg::CFG_MEASUREMENT_NOISE) begin
        mn_r <= cfg_data;
      end
      if (cmd.prime) begin
        est_r <= in_measurement;
        var_r <= mn_r;
      end else if (cmd.update) begin
        est_r <= est_new;
        var_r <= prod_v_r[GB+W-1:GB];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      meas_r <= in_measurement;
    end
    if (cmd.predict) begin
      pq_r <= p_sat;
    end
    if (cmd.div_init) begin
      den_r <= {1'b0, pq_r} + {1'b0, mn_r};
      rem_r <= {1'b0, pq_r};
      byp_r <= (mn_r == '0);
      g_r   <= (mn_r == '0) ? skf_pkg::GAIN_MAX : '0;
    end else if (cmd.div_step && !byp_r) begin
      rem_r <= rem_ge ? rem_sub[W:0] : rem_sh[W:0];
      g_r   <= {g_r[GB-2:0], rem_ge};
    end
    if (cmd.mul) begin
      prod_e_r <= prod_e_nxt;
      prod_v_r <= prod_v_nxt;
    end
    if (cmd.out_load) begin
      out_est_r <= est_r;
      out_rnd_r <= rnd_sat;
      out_var_r <= var_r;
    end
  end

  assign out_estimate         = out_est_r;
  assign out_rounded_estimate = out_rnd_r;
  assign out_error_variance   = out_var_r;

endmodule

### rtl/scalar_kalman_filter_core.sv
// The first sample after reset primes the filter and is loaded straight into the output
// register. Later samples pass through predict, divider init, the divider steps, multiply
// and update first. The output load waits until the output register is free, and a new
// sample is taken only after it, while the previous result may still wait in the output register.
// Reset: synchronous, active low; clears the primed flag and the estimate, sets the covariance
// to one, and returns both noise registers to their defaults.
module scalar_kalman_filter_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [skf_pkg::DATA_W-1:0]   in_measurement,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [skf_pkg::DATA_W-1:0]   out_estimate,
  output logic signed [skf_pkg::RND_W-1:0]    out_rounded_estimate,
  output logic [skf_pkg::DATA_W-1:0]          out_error_variance,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [skf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [skf_pkg::DATA_W-1:0]          cfg_data
);

  skf_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  skf_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .cfg_we               (cfg_valid && cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_measurement       (in_measurement),
    .out_estimate         (out_estimate),
    .out_rounded_estimate (out_rounded_estimate),
    .out_error_variance   (out_error_variance)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready after a transfer");

  a_result_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_ready) |-> out_valid)
    else $error("block went idle without presenting a result");
`endif

endmodule
